// File: rtl/wavmix_pkg.sv
// ----------------------------------------------------------------------------
// wavmix_pkg
// Shared types, codes and defaults for the wavetable voice mixer.
// ----------------------------------------------------------------------------
package wavmix_pkg;

  // default sizes
  localparam int VOICES_DEF     = 8;
  localparam int WAVE_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 12;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ADSR    = 3'd5;

  // request operations
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PLAY = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_WAVE = 2'd3;

  // envelope phases
  localparam logic [2:0] ENV_OFF     = 3'd0;
  localparam logic [2:0] ENV_ATTACK  = 3'd1;
  localparam logic [2:0] ENV_DECAY   = 3'd2;
  localparam logic [2:0] ENV_SUSTAIN = 3'd3;
  localparam logic [2:0] ENV_RELEASE = 3'd4;

  localparam logic [17:0] FULL_VOL = 18'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic [19:0]        note_step;
    logic [9:0]         wave_addr;
    logic signed [7:0]  wave_data;
  } in_t;

  typedef struct packed {
    logic signed [7:0]  mixed_sample;
    logic               sample_valid;
    logic               play_accepted;
    logic [3:0]         active_voices;
  } out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
    logic mul;
    logic acc;
    logic fin;
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic in_tick;
    logic last_voice;
  } sts_t;

endpackage

// File: rtl/wavetable_adsr_voice_mixer_top.sv
// ----------------------------------------------------------------------------
// wavetable_adsr_voice_mixer_top
// Polyphonic wavetable mixer with per-voice ADSR envelopes.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  request   start, request, busy             start && !busy
//  result    done, result                     one-cycle strobe, no stall
//  config    cfg_we, cfg_addr, cfg_data       cfg_we, any cycle while idle
//
//  A tick walks every voice (table read, multiply, add), then finishes.
//  Play, stop all and wave write run an execute step, then the finish step.
//  rst is synchronous and clears the active voices, the configuration registers, the control state and done.
//  done is registered from the finish state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module wavetable_adsr_voice_mixer_top #(
  parameter int VOICES     = wavmix_pkg::VOICES_DEF,
  parameter int WAVE_DEPTH = wavmix_pkg::WAVE_DEPTH_DEF,
  parameter int FRAC_BITS  = wavmix_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  wavmix_pkg::in_t                  request,
  output logic                             busy,
  output logic                             done,
  output wavmix_pkg::out_t                 result,
  input  logic                             cfg_we,
  input  logic [wavmix_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [wavmix_pkg::CFG_W-1:0]     cfg_data
);
  import wavmix_pkg::*;

  ctl_t ctl;
  sts_t sts;

  wavmix_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  wavmix_dp #(
    .VOICES     (VOICES),
    .WAVE_DEPTH (WAVE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

endmodule

// File: rtl/wavmix_ram.sv
// ----------------------------------------------------------------------------
// wavmix_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wavmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wavmix_ctrl.sv
// ----------------------------------------------------------------------------
// wavmix_ctrl
// Sequencer: walks the voices for a tick, single step for other requests.
// ----------------------------------------------------------------------------
module wavmix_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  wavmix_pkg::sts_t   sts,
  output wavmix_pkg::ctl_t   ctl,
  output logic               busy
);
  import wavmix_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = sts.in_tick ? ST_RD : ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_FIN;
      ST_RD:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = sts.last_voice ? ST_FIN : ST_RD;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command decode
  always_comb begin
    ctl.load = (state == ST_IDLE) && start;
    ctl.exec = (state == ST_EXEC);
    ctl.rd   = (state == ST_RD);
    ctl.mul  = (state == ST_MUL);
    ctl.acc  = (state == ST_ACC);
    ctl.fin  = (state == ST_FIN);
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/wavmix_dp.sv
// ----------------------------------------------------------------------------
// wavmix_dp
// Voice state, envelope step, sample multiply, mix accumulator, result reg.
// ----------------------------------------------------------------------------
module wavmix_dp #(
  parameter int VOICES     = wavmix_pkg::VOICES_DEF,
  parameter int WAVE_DEPTH = wavmix_pkg::WAVE_DEPTH_DEF,
  parameter int FRAC_BITS  = wavmix_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wavmix_pkg::ctl_t                ctl,
  output wavmix_pkg::sts_t                sts,
  input  wavmix_pkg::in_t                 request,
  input  logic                            cfg_we,
  input  logic [wavmix_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [wavmix_pkg::CFG_W-1:0]    cfg_data,
  output wavmix_pkg::out_t                result,
  output logic                            done
);
  import wavmix_pkg::*;

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = $clog2(WAVE_DEPTH);
  localparam int PH_W  = ((AW + FRAC_BITS) > 20 ? (AW + FRAC_BITS) : 20) + 1;
  localparam int SUM_W = 11 + $clog2(VOICES) + 1;
  localparam logic [PH_W:0] WAVE_END = (PH_W+1)'(WAVE_DEPTH) << FRAC_BITS;
  localparam logic signed [SUM_W-3:0] SAT_HI = 127;
  localparam logic signed [SUM_W-3:0] SAT_LO = -128;
  localparam logic signed [19:0] FULL_S = 20'sd65536;

  // configuration registers
  logic [16:0] attack_step, decay_step, sustain_level, release_step;
  logic [23:0] sustain_ticks;
  logic        adsr_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= '0;
      decay_step    <= '0;
      sustain_level <= '0;
      sustain_ticks <= '0;
      release_step  <= '0;
      adsr_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ATTACK:  attack_step   <= cfg_data[16:0];
        CFG_DECAY:   decay_step    <= cfg_data[16:0];
        CFG_LEVEL:   sustain_level <= cfg_data[16:0];
        CFG_SUSTAIN: sustain_ticks <= cfg_data;
        CFG_RELEASE: release_step  <= cfg_data[16:0];
        CFG_ADSR:    adsr_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // voice state
  logic [VOICES-1:0] voice_active;
  logic [2:0]        envelope_phase  [VOICES];
  logic [17:0]       voice_volume    [VOICES];
  logic [PH_W-1:0]   voice_phase     [VOICES];
  logic [19:0]       voice_increment [VOICES];
  logic [23:0]       sustain_left    [VOICES];
  logic [16:0]       latched_attack  [VOICES];
  logic [16:0]       latched_decay   [VOICES];
  logic [16:0]       latched_level   [VOICES];
  logic [16:0]       latched_release [VOICES];

  in_t                     req;
  logic [VW-1:0]           vi;
  logic signed [SUM_W-1:0] sum;
  logic signed [26:0]      prod;
  logic                    accepted;

  // wave table
  logic          wave_we;
  logic [AW-1:0] wave_raddr;
  logic [7:0]    wave_rdata;

  assign wave_we    = ctl.exec && (req.op == OP_WAVE) &&
                      ({22'd0, req.wave_addr} < 32'(WAVE_DEPTH));
  assign wave_raddr = voice_phase[vi][FRAC_BITS +: AW];

  wavmix_ram #(.WIDTH(8), .DEPTH(WAVE_DEPTH)) u_wave (
    .clk   (clk),
    .we    (wave_we),
    .waddr (AW'(req.wave_addr)),
    .wdata (req.wave_data),
    .raddr (wave_raddr),
    .rdata (wave_rdata)
  );

  // first free voice
  logic          free_found;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!free_found && !voice_active[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  // active count
  logic [5:0] cnt;
  always_comb begin
    cnt = '0;
    for (int v = 0; v < VOICES; v++) begin
      cnt = cnt + 6'(voice_active[v]);
    end
  end

  // envelope step for the current voice
  logic signed [19:0] vol_cur, vol_next;
  logic [2:0]         env_next;
  logic [23:0]        sus_next;
  logic               rel_end;
  logic [PH_W:0]      phase_sum;
  logic signed [26:0] product;

  always_comb begin
    vol_cur  = $signed({2'b00, voice_volume[vi]});
    vol_next = vol_cur;
    env_next = envelope_phase[vi];
    sus_next = sustain_left[vi];
    rel_end  = 1'b0;
    unique case (envelope_phase[vi])
      ENV_ATTACK: begin
        vol_next = vol_cur + $signed({3'b000, latched_attack[vi]});
        if (vol_next >= FULL_S) begin
          vol_next = FULL_S;
          env_next = ENV_DECAY;
        end
      end
      ENV_DECAY: begin
        vol_next = vol_cur - $signed({3'b000, latched_decay[vi]});
        if (vol_next <= $signed({3'b000, latched_level[vi]})) begin
          vol_next = $signed({3'b000, latched_level[vi]});
          env_next = ENV_SUSTAIN;
        end
      end
      ENV_SUSTAIN: begin
        if (sustain_left[vi] != '0) begin
          sus_next = sustain_left[vi] - 24'd1;
        end else begin
          env_next = ENV_RELEASE;
        end
      end
      ENV_RELEASE: begin
        vol_next = vol_cur - $signed({3'b000, latched_release[vi]});
        rel_end  = (vol_next <= 20'sd0);
      end
      default: ;
    endcase
    product   = $signed(wave_rdata) * $signed({1'b0, vol_next[17:0]});
    phase_sum = {1'b0, voice_phase[vi]} + (PH_W+1)'(voice_increment[vi]);
  end

  // voice state update
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
    end else if (ctl.exec && req.op == OP_STOP) begin
      voice_active <= '0;
    end else if (ctl.exec && req.op == OP_PLAY && free_found) begin
      voice_active[free_idx]    <= 1'b1;
      voice_phase[free_idx]     <= '0;
      voice_increment[free_idx] <= req.note_step;
      latched_attack[free_idx]  <= attack_step;
      latched_decay[free_idx]   <= decay_step;
      latched_level[free_idx]   <= sustain_level;
      sustain_left[free_idx]    <= sustain_ticks;
      latched_release[free_idx] <= release_step;
      if (adsr_enable) begin
        envelope_phase[free_idx] <= ENV_ATTACK;
        voice_volume[free_idx]   <= '0;
      end else begin
        envelope_phase[free_idx] <= ENV_OFF;
        voice_volume[free_idx]   <= FULL_VOL;
      end
    end else if (ctl.mul && voice_active[vi]) begin
      if (rel_end) begin
        voice_volume[vi] <= '0;
        voice_active[vi] <= 1'b0;
      end else begin
        voice_volume[vi] <= vol_next[17:0];
        sustain_left[vi] <= sus_next;
        // wave end: loop into release, or end a one-shot voice
        if (phase_sum >= WAVE_END && adsr_enable) begin
          envelope_phase[vi] <= ENV_RELEASE;
          voice_phase[vi]    <= PH_W'(phase_sum - WAVE_END);
        end else begin
          envelope_phase[vi] <= env_next;
          voice_phase[vi]    <= PH_W'(phase_sum);
          if (phase_sum >= WAVE_END) begin
            voice_active[vi] <= 1'b0;
          end
        end
      end
    end
  end

  // request latch, voice walk, mix accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req      <= request;
      vi       <= '0;
      sum      <= '0;
      accepted <= 1'b0;
    end
    if (ctl.exec) begin
      accepted <= (req.op == OP_PLAY) && free_found;
    end
    if (ctl.mul) begin
      prod <= (voice_active[vi] && !rel_end) ? product : '0;
    end
    if (ctl.acc) begin
      sum <= sum + SUM_W'($signed(prod[26:16]));
      if (!sts.last_voice) begin
        vi <= vi + VW'(1);
      end
    end
  end

  assign sts.in_tick    = (request.op == OP_TICK);
  assign sts.last_voice = (vi == VW'(VOICES - 1));

  // saturate mix
  logic signed [SUM_W-3:0] mix_sh;
  logic signed [7:0]       mix_sat;
  always_comb begin
    mix_sh = sum[SUM_W-1:2];
    if (mix_sh > SAT_HI) begin
      mix_sat = 8'sd127;
    end else if (mix_sh < SAT_LO) begin
      mix_sat = -8'sd128;
    end else begin
      mix_sat = mix_sh[7:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.fin;
    end
    if (ctl.fin) begin
      result.mixed_sample  <= (req.op == OP_TICK) ? mix_sat : 8'sd0;
      result.sample_valid  <= (req.op == OP_TICK);
      result.play_accepted <= (req.op == OP_PLAY) && accepted;
      result.active_voices <= cnt[3:0];
    end
  end

  // checks
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.fin)) else $error("result without finish");
  a_tick_no_play: assert property (@(posedge clk) disable iff (rst)
    (done && result.sample_valid) |-> !result.play_accepted)
    else $error("tick result flags a play");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 6'(VOICES)) else $error("active count out of range");

endmodule
